FILE: hw/rtl/bfct_pkg.sv
// Package for the bidirectional flow counter table.
// Key, counter and record types shared by the RAM users and the update logic.
// No dependencies.
package bfct_pkg;

    localparam logic [63:0] NO_TIME = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] cid;
        logic [5:0]  typ;
    } key_t;

    typedef struct packed {
        logic [63:0] frames_total;
        logic [63:0] bytes_total;
        logic [63:0] frames_shown;
        logic [63:0] bytes_shown;
    } dir_t;

    typedef struct packed {
        dir_t        tx;
        dir_t        rx;
        logic [63:0] t_start;
        logic [63:0] t_stop;
        logic [63:0] t_abs;
        logic        shown;
    } rec_t;

    typedef struct packed {
        logic        is_new;
        logic        is_fwd;
        logic        shown_en;
        logic [15:0] frames;
        logic [23:0] bytes;
        logic [63:0] ts;
        logic [63:0] abs_ts;
    } upd_ctl_t;

endpackage

FILE: hw/rtl/bfct_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module bfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bfct_rec_update.sv
// Record update: counter adds, shown mark and time span widening.
// Depends on bfct_pkg.
module bfct_rec_update (
    input  bfct_pkg::rec_t     old_rec,
    input  bfct_pkg::upd_ctl_t ctl,
    output bfct_pkg::rec_t     new_rec,
    output bfct_pkg::dir_t     cnt
);

    bfct_pkg::rec_t base;
    bfct_pkg::dir_t d;
    logic           ts_set;
    logic           later;
    logic           earlier;

    always_comb begin
        ts_set = (ctl.ts != bfct_pkg::NO_TIME);
        base = old_rec;
        if (ctl.is_new) begin
            base = '0;
            base.t_start = ts_set ? ctl.ts : bfct_pkg::NO_TIME;
            base.t_stop  = ts_set ? ctl.ts : bfct_pkg::NO_TIME;
            base.t_abs   = ts_set ? ctl.abs_ts : bfct_pkg::NO_TIME;
        end
        d = ctl.is_fwd ? base.tx : base.rx;
        d.frames_total = d.frames_total + 64'(ctl.frames);
        d.bytes_total  = d.bytes_total + 64'(ctl.bytes);
        if (ctl.shown_en) begin
            d.frames_shown = d.frames_shown + 64'(ctl.frames);
            d.bytes_shown  = d.bytes_shown + 64'(ctl.bytes);
        end
        new_rec = base;
        if (ctl.is_fwd) begin
            new_rec.tx = d;
        end else begin
            new_rec.rx = d;
        end
        if (ctl.shown_en) begin
            new_rec.shown = 1'b1;
        end
        // unset stored time orders below every set time
        later   = (base.t_stop == bfct_pkg::NO_TIME) || (ctl.ts > base.t_stop);
        earlier = (base.t_start != bfct_pkg::NO_TIME) && (ctl.ts < base.t_start);
        if (ts_set) begin
            if (later) begin
                new_rec.t_stop = ctl.ts;
            end else if (earlier) begin
                new_rec.t_start = ctl.ts;
                new_rec.t_abs   = ctl.abs_ts;
            end
        end
        cnt = d;
    end

endmodule

FILE: hw/rtl/bidirectional_flow_counter_table_unit.sv
// Bidirectional flow counter table top level: key scan, entry allocation and record update.
// Depends on bfct_pkg, bfct_ram and bfct_rec_update.
//
// Each item scans the key RAM one entry per cycle over the entries stored so far, stopping
// at the first exact-orientation match and remembering the first reverse match, then reads,
// updates and, unless the table is full, writes back the entry's record in the record RAM.
// The scan length grows with the entries stored and ends early on a forward hit; the single
// read port of the key RAM sets it. One item is in work at a time; the next item is taken
// while the previous result waits in the output register. Memories need no clearing pass:
// only key entries below the fill count are read; a new entry's record is zeroed in the update.
module bidirectional_flow_counter_table_unit #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_src_addr_hi,
    input  logic [63:0] s_src_addr_lo,
    input  logic [63:0] s_dst_addr_hi,
    input  logic [63:0] s_dst_addr_lo,
    input  logic [5:0]  s_addr_type,
    input  logic [31:0] s_src_port,
    input  logic [31:0] s_dst_port,
    input  logic [31:0] s_conv_ident,
    input  logic [15:0] s_frame_count,
    input  logic [23:0] s_byte_count,
    input  logic [63:0] s_rel_time,
    input  logic [63:0] s_abs_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_entry_index,
    output logic        m_is_new,
    output logic        m_is_forward,
    output logic        m_table_full,
    output logic [63:0] m_frames_total,
    output logic [63:0] m_bytes_total,
    output logic [63:0] m_frames_shown,
    output logic [63:0] m_bytes_shown,
    output logic [63:0] m_first_time,
    output logic [63:0] m_last_time,
    output logic [63:0] m_start_abs,
    output logic        m_shown_mark
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = $bits(bfct_pkg::key_t);
    localparam int RW = $bits(bfct_pkg::rec_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              dfi_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic              rev_hit_reg, rev_hit_next;
    logic [IW-1:0]     fwd_idx_reg, fwd_idx_next;
    logic [IW-1:0]     rev_idx_reg, rev_idx_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              new_reg, new_next;
    logic              dir_reg, dir_next;
    logic              full_reg, full_next;

    bfct_pkg::key_t    fkey_reg;
    bfct_pkg::key_t    rkey;
    logic [15:0]       frames_reg;
    logic [23:0]       bytes_reg;
    logic [63:0]       ts_reg;
    logic [63:0]       abs_reg;

    logic [KW-1:0]     key_rdata;
    bfct_pkg::key_t    rd_key;
    logic              key_re, key_we;
    logic [RW-1:0]     rec_rdata;
    logic              rec_re, rec_we;
    logic [IW-1:0]     rec_raddr;
    bfct_pkg::rec_t    new_rec;
    bfct_pkg::dir_t    cnt;
    bfct_pkg::upd_ctl_t ctl;
    logic              out_load;
    logic              hit_f, hit_r;
    logic [31:0]       idx_ext;

    logic              m_valid_reg;
    logic [9:0]        m_index_reg;
    logic              m_new_reg, m_fwd_reg, m_full_reg, m_mark_reg;
    bfct_pkg::dir_t    m_cnt_reg;
    logic [63:0]       m_start_reg, m_stop_reg, m_abs_reg;

    always_comb begin
        rkey      = fkey_reg;
        rkey.a_hi = fkey_reg.b_hi;
        rkey.a_lo = fkey_reg.b_lo;
        rkey.b_hi = fkey_reg.a_hi;
        rkey.b_lo = fkey_reg.a_lo;
        rkey.pa   = fkey_reg.pb;
        rkey.pb   = fkey_reg.pa;
    end

    assign rd_key = bfct_pkg::key_t'(key_rdata);
    assign hit_f  = pend_reg && (rd_key == fkey_reg);
    assign hit_r  = pend_reg && (rd_key == rkey);
    assign key_re = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        fwd_hit_next  = fwd_hit_reg;
        rev_hit_next  = rev_hit_reg;
        fwd_idx_next  = fwd_idx_reg;
        rev_idx_next  = rev_idx_reg;
        idx_next      = idx_reg;
        new_next      = new_reg;
        dir_next      = dir_reg;
        full_next     = full_reg;
        key_we        = 1'b0;
        rec_re        = 1'b0;
        rec_raddr     = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next   = ST_SCAN;
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    fwd_hit_next = 1'b0;
                    rev_hit_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (hit_f) begin
                    fwd_hit_next = 1'b1;
                    fwd_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = ST_DEC;
                end else begin
                    if (hit_r && !rev_hit_reg) begin
                        rev_hit_next = 1'b1;
                        rev_idx_next = pend_idx_reg;
                    end
                    if (issue_reg < count_reg) begin
                        issue_next    = issue_reg + 1'b1;
                        pend_next     = 1'b1;
                        pend_idx_next = issue_reg[IW-1:0];
                    end else begin
                        pend_next = 1'b0;
                        if (!pend_reg) begin
                            state_next = ST_DEC;
                        end
                    end
                end
            end
            ST_DEC: begin
                full_next = 1'b0;
                new_next  = 1'b0;
                if (fwd_hit_reg) begin
                    idx_next = fwd_idx_reg;
                    dir_next = 1'b1;
                end else if (rev_hit_reg) begin
                    idx_next = rev_idx_reg;
                    dir_next = 1'b0;
                end else if (count_reg == CW'(TABLE_ENTRIES)) begin
                    full_next = 1'b1;
                    idx_next  = '0;
                    dir_next  = 1'b0;
                end else begin
                    idx_next   = count_reg[IW-1:0];
                    dir_next   = 1'b1;
                    new_next   = 1'b1;
                    key_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                rec_raddr  = idx_next;
                rec_re     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rec_we = out_load && !full_reg;

    always_comb begin
        ctl.is_new   = new_reg;
        ctl.is_fwd   = dir_reg;
        ctl.shown_en = !dfi_reg;
        ctl.frames   = frames_reg;
        ctl.bytes    = bytes_reg;
        ctl.ts       = ts_reg;
        ctl.abs_ts   = abs_reg;
    end

    bfct_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (fkey_reg),
        .re    (key_re),
        .raddr (issue_reg[IW-1:0]),
        .rdata (key_rdata)
    );

    bfct_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (idx_reg),
        .wdata (new_rec),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    bfct_rec_update u_update (
        .old_rec (bfct_pkg::rec_t'(rec_rdata)),
        .ctl     (ctl),
        .new_rec (new_rec),
        .cnt     (cnt)
    );

    assign idx_ext = 32'(idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dfi_reg     <= 1'b0;
            count_reg   <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            fwd_hit_reg <= 1'b0;
            rev_hit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            fwd_hit_reg <= fwd_hit_next;
            rev_hit_reg <= rev_hit_next;
            if (cfg_wr_en) begin
                dfi_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        fwd_idx_reg  <= fwd_idx_next;
        rev_idx_reg  <= rev_idx_next;
        idx_reg      <= idx_next;
        new_reg      <= new_next;
        dir_reg      <= dir_next;
        full_reg     <= full_next;
        if (s_valid && s_ready) begin
            fkey_reg.a_hi <= s_src_addr_hi;
            fkey_reg.a_lo <= s_src_addr_lo;
            fkey_reg.b_hi <= s_dst_addr_hi;
            fkey_reg.b_lo <= s_dst_addr_lo;
            fkey_reg.pa   <= s_src_port;
            fkey_reg.pb   <= s_dst_port;
            fkey_reg.cid  <= s_conv_ident;
            fkey_reg.typ  <= s_addr_type;
            frames_reg    <= s_frame_count;
            bytes_reg     <= s_byte_count;
            ts_reg        <= s_rel_time;
            abs_reg       <= s_abs_time;
        end
        if (out_load) begin
            if (full_reg) begin
                m_index_reg <= '0;
                m_new_reg   <= 1'b0;
                m_fwd_reg   <= 1'b0;
                m_full_reg  <= 1'b1;
                m_cnt_reg   <= '0;
                m_start_reg <= '0;
                m_stop_reg  <= '0;
                m_abs_reg   <= '0;
                m_mark_reg  <= 1'b0;
            end else begin
                m_index_reg <= idx_ext[9:0];
                m_new_reg   <= new_reg;
                m_fwd_reg   <= dir_reg;
                m_full_reg  <= 1'b0;
                m_cnt_reg   <= cnt;
                m_start_reg <= new_rec.t_start;
                m_stop_reg  <= new_rec.t_stop;
                m_abs_reg   <= new_rec.t_abs;
                m_mark_reg  <= new_rec.shown;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_index  = m_index_reg;
    assign m_is_new       = m_new_reg;
    assign m_is_forward   = m_fwd_reg;
    assign m_table_full   = m_full_reg;
    assign m_frames_total = m_cnt_reg.frames_total;
    assign m_bytes_total  = m_cnt_reg.bytes_total;
    assign m_frames_shown = m_cnt_reg.frames_shown;
    assign m_bytes_shown  = m_cnt_reg.bytes_shown;
    assign m_first_time   = m_start_reg;
    assign m_last_time    = m_stop_reg;
    assign m_start_abs    = m_abs_reg;
    assign m_shown_mark   = m_mark_reg;

endmodule

FILE: hw/rtl/bfct_checker.sv
// Port-level assertions for the flow counter table, bound to the top level.
// Depends on bidirectional_flow_counter_table_unit.
module bfct_port_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_entry_index,
    input logic       m_is_new,
    input logic       m_is_forward,
    input logic       m_table_full
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice without processing");

    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> !m_is_new && !m_is_forward && m_entry_index == 10'd0)
        else $error("table full item carries entry data");

    a_new_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_new |-> m_is_forward && !m_table_full)
        else $error("new entry not counted forward");

endmodule

bind bidirectional_flow_counter_table_unit bfct_port_props u_bfct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_entry_index (m_entry_index),
    .m_is_new      (m_is_new),
    .m_is_forward  (m_is_forward),
    .m_table_full  (m_table_full)
);
